// ----- design/calendar_date_counter_macros.svh -----
// Assertion macros used by the checker file.
`ifndef CALENDAR_DATE_COUNTER_MACROS_SVH
`define CALENDAR_DATE_COUNTER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("calendar_date_counter assertion failed");

// Next-cycle implication, disabled during reset
`define CDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("calendar_date_counter assertion failed");

`endif

// ----- design/cdc_pkg.sv -----
package cdc_pkg;

	// Field widths
	localparam int MonthW = 4;
	localparam int DayW   = 5;
	localparam int YearW  = 16;
	localparam int CountW = 16;
	localparam int CfgW   = 16;

	// Step count limit for an advance
	localparam logic [31:0] MAX_ADVANCE = 32'd65535;

	// Reset values
	localparam logic [YearW-1:0]  YearMinReset = 16'd1980;
	localparam logic [YearW-1:0]  YearMaxReset = 16'd2100;
	localparam logic [YearW-1:0]  YearReset    = 16'd1980;
	localparam logic [MonthW-1:0] MonthReset   = 4'd1;
	localparam logic [DayW-1:0]   DayReset     = 5'd1;

	// Configuration register indexes
	localparam logic REG_YEAR_MIN = 1'b0;
	localparam logic REG_YEAR_MAX = 1'b1;

	// Command codes
	localparam logic CMD_SET     = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	// Months with special lengths
	localparam logic [MonthW-1:0] MonthJan = 4'd1;
	localparam logic [MonthW-1:0] MonthFeb = 4'd2;
	localparam logic [MonthW-1:0] MonthApr = 4'd4;
	localparam logic [MonthW-1:0] MonthJun = 4'd6;
	localparam logic [MonthW-1:0] MonthSep = 4'd9;
	localparam logic [MonthW-1:0] MonthNov = 4'd11;
	localparam logic [MonthW-1:0] MonthDec = 4'd12;

	// Divisibility by 25: y * inverse(25) mod 2^16 lands at or below 65535/25
	localparam logic [YearW-1:0] Inv25   = 16'd23593;
	localparam logic [YearW-1:0] Limit25 = 16'd2621;

	// Microcode operations
	localparam int OpW = 3;
	localparam logic [OpW-1:0] OP_NOP      = 3'd0;
	localparam logic [OpW-1:0] OP_ACCEPT   = 3'd1;
	localparam logic [OpW-1:0] OP_STEP     = 3'd2;
	localparam logic [OpW-1:0] OP_EMIT     = 3'd3;
	localparam logic [OpW-1:0] OP_SET_YEAR = 3'd4;
	localparam logic [OpW-1:0] OP_SET_MD   = 3'd5;

	// Microcode jump conditions
	localparam int CondW = 3;
	localparam logic [CondW-1:0] C_ALWAYS    = 3'd0;
	localparam logic [CondW-1:0] C_IN_ACC    = 3'd1;
	localparam logic [CondW-1:0] C_CMD_ADV   = 3'd2;
	localparam logic [CondW-1:0] C_CNT_NZ    = 3'd3;
	localparam logic [CondW-1:0] C_OUT_BLOCK = 3'd4;

	// Program steps
	localparam int PcW = 3;
	localparam logic [PcW-1:0] PC_WAIT     = 3'd0;
	localparam logic [PcW-1:0] PC_DISPATCH = 3'd1;
	localparam logic [PcW-1:0] PC_ADVANCE  = 3'd2;
	localparam logic [PcW-1:0] PC_EMIT     = 3'd3;
	localparam logic [PcW-1:0] PC_SET_YEAR = 3'd4;
	localparam logic [PcW-1:0] PC_SETTLE   = 3'd5;
	localparam logic [PcW-1:0] PC_SET_MD   = 3'd6;

	typedef struct packed {
		logic [OpW-1:0]   op;
		logic [CondW-1:0] cond;
		logic [PcW-1:0]   taken;
		logic [PcW-1:0]   fall;
	} ctl_word_t;

	typedef struct packed {
		logic              cmd;
		logic [MonthW-1:0] new_month;
		logic [DayW-1:0]   new_day;
		logic [YearW-1:0]  new_year;
		logic [CountW-1:0] days_to_add;
	} in_item_t;

	typedef struct packed {
		logic [MonthW-1:0] cur_month;
		logic [DayW-1:0]   cur_day;
		logic [YearW-1:0]  cur_year;
		logic              year_error;
		logic              month_error;
		logic              day_error;
	} out_item_t;

	// Control store
	function automatic ctl_word_t program_rom(input logic [PcW-1:0] pc);
		ctl_word_t w;
		case (pc)
			PC_WAIT:     w = '{OP_ACCEPT,   C_IN_ACC,    PC_DISPATCH, PC_WAIT};
			PC_DISPATCH: w = '{OP_NOP,      C_CMD_ADV,   PC_ADVANCE,  PC_SET_YEAR};
			PC_ADVANCE:  w = '{OP_STEP,     C_CNT_NZ,    PC_ADVANCE,  PC_EMIT};
			PC_EMIT:     w = '{OP_EMIT,     C_OUT_BLOCK, PC_EMIT,     PC_WAIT};
			PC_SET_YEAR: w = '{OP_SET_YEAR, C_ALWAYS,    PC_SETTLE,   PC_SETTLE};
			PC_SETTLE:   w = '{OP_NOP,      C_ALWAYS,    PC_SET_MD,   PC_SET_MD};
			PC_SET_MD:   w = '{OP_SET_MD,   C_ALWAYS,    PC_EMIT,     PC_EMIT};
			default:     w = '{OP_NOP,      C_ALWAYS,    PC_WAIT,     PC_WAIT};
		endcase
		return w;
	endfunction

	// Gregorian leap rule; year 0 counts as leap
	function automatic logic leap_of(input logic [YearW-1:0] y);
		logic [2*YearW-1:0] full;
		logic               div25;
		full  = {{YearW{1'b0}}, y} * {{YearW{1'b0}}, Inv25};
		div25 = (full[YearW-1:0] <= Limit25);
		return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
	endfunction

	// Month length; zero for a month outside 1 to 12
	function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
		logic [DayW-1:0] len;
		if (m == MonthFeb) begin
			len = leap ? 5'd29 : 5'd28;
		end else if (m == MonthApr || m == MonthJun || m == MonthSep || m == MonthNov) begin
			len = 5'd30;
		end else if (m >= MonthJan && m <= MonthDec) begin
			len = 5'd31;
		end else begin
			len = 5'd0;
		end
		return len;
	endfunction

endpackage

// ----- design/calendar_date_counter.sv -----
// Gregorian date counter. Holds month, day and year and answers every item
// with one result carrying the stored date and the set error flags. A set
// item (cmd 0) loads year, then month and day, each only when valid; a day
// is checked against the requested month using the leap rule of the stored
// year. An advance item (cmd 1) steps days_to_add days, capped at
// MAX_ADVANCE, wrapping year 65535 to 0. A small microcode program runs the
// work; the step loop of an advance moves one day per cycle. A result
// waiting on a stalled output does not block the next accept; the emit
// step waits only if the output register is still full and stalled.
module calendar_date_counter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_idx,
	input  logic [cdc_pkg::CfgW-1:0]   cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  cdc_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output cdc_pkg::out_item_t         out_data
);
	import cdc_pkg::*;

	logic [PcW-1:0]    pc_q;
	ctl_word_t         ctl;
	logic              cond_true;
	logic              in_acc;
	logic              out_free;
	logic [YearW-1:0]  year_min_q, year_max_q;
	in_item_t          item_q;
	logic [CountW-1:0] cnt_q;
	logic [MonthW-1:0] month_q;
	logic [DayW-1:0]   day_q;
	logic [YearW-1:0]  year_q;
	logic              leap_q;
	logic              yerr_q, merr_q, derr_q;
	logic              out_valid_q;
	out_item_t         out_q;
	logic [DayW-1:0]   cur_len;
	logic [DayW-1:0]   set_len;
	logic              set_month_ok;

	// Fetch the control word of the current step
	always_comb begin
		ctl = program_rom(pc_q);
	end

	assign in_stall  = (ctl.op != OP_ACCEPT);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Evaluate the jump condition
	always_comb begin
		case (ctl.cond)
			C_ALWAYS:    cond_true = 1'b1;
			C_IN_ACC:    cond_true = in_acc;
			C_CMD_ADV:   cond_true = (item_q.cmd == CMD_ADVANCE);
			C_CNT_NZ:    cond_true = (cnt_q != '0);
			C_OUT_BLOCK: cond_true = !out_free;
			default:     cond_true = 1'b1;
		endcase
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else begin
			pc_q <= cond_true ? ctl.taken : ctl.fall;
		end
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_min_q <= YearMinReset;
			year_max_q <= YearMaxReset;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_YEAR_MIN: year_min_q <= cfg_wdata;
				REG_YEAR_MAX: year_max_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Track the leap flag of the stored year, updated in the cycle after the year changes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leap_q <= leap_of(YearReset);
		end else begin
			leap_q <= leap_of(year_q);
		end
	end

	assign cur_len      = month_len(month_q, leap_q);
	assign set_len      = month_len(item_q.new_month, leap_q);
	assign set_month_ok = (item_q.new_month >= MonthJan) && (item_q.new_month <= MonthDec);

	// Latch the item and load the step count
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_data;
			cnt_q  <= ({16'd0, in_data.days_to_add} > MAX_ADVANCE) ?
				MAX_ADVANCE[CountW-1:0] : in_data.days_to_add;
		end else if (ctl.op == OP_STEP && cnt_q != '0) begin
			cnt_q <= cnt_q - 16'd1;
		end
	end

	// Update the stored date and the error flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			month_q <= MonthReset;
			day_q   <= DayReset;
			year_q  <= YearReset;
			yerr_q  <= 1'b0;
			merr_q  <= 1'b0;
			derr_q  <= 1'b0;
		end else begin
			case (ctl.op)
				OP_ACCEPT: begin
					if (in_acc) begin
						yerr_q <= 1'b0;
						merr_q <= 1'b0;
						derr_q <= 1'b0;
					end
				end
				OP_STEP: begin
					if (cnt_q != '0) begin
						if (day_q >= cur_len) begin
							day_q <= DayReset;
							if (month_q >= MonthDec) begin
								month_q <= MonthJan;
								year_q  <= year_q + 16'd1;
							end else begin
								month_q <= month_q + 4'd1;
							end
						end else begin
							day_q <= day_q + 5'd1;
						end
					end
				end
				OP_SET_YEAR: begin
					if (item_q.new_year >= year_min_q && item_q.new_year <= year_max_q) begin
						year_q <= item_q.new_year;
					end else begin
						yerr_q <= 1'b1;
					end
				end
				OP_SET_MD: begin
					if (set_month_ok) begin
						month_q <= item_q.new_month;
						if (item_q.new_day >= 5'd1 && item_q.new_day <= set_len) begin
							day_q <= item_q.new_day;
						end else begin
							derr_q <= 1'b1;
						end
					end else begin
						merr_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Hold the result until taken; load a new one when the slot frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.op == OP_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_EMIT && out_free) begin
			out_q <= '{month_q, day_q, year_q, yerr_q, merr_q, derr_q};
		end
	end

endmodule

// ----- design/cdc_checker.sv -----
`include "calendar_date_counter_macros.svh"

module cdc_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input cdc_pkg::out_item_t       out_data
);
	import cdc_pkg::*;

	// A stalled result stays offered
	`CDC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// The block is busy right after taking an item
	`CDC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// Every result carries a real month
	`CDC_ASSERT_NOW(a_month_range, clk, arst_n, out_valid,
		out_data.cur_month >= MonthJan && out_data.cur_month <= MonthDec)

	// Every result carries a day from 1 to 31
	`CDC_ASSERT_NOW(a_day_range, clk, arst_n, out_valid,
		out_data.cur_day >= 5'd1 && out_data.cur_day <= 5'd31)

	// A bad month skips the day check
	`CDC_ASSERT_NOW(a_month_err_no_day_err, clk, arst_n, out_valid && out_data.month_error,
		!out_data.day_error)

endmodule

bind calendar_date_counter cdc_checker u_cdc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
